FILE: hdl/mhpq_pkg.sv
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int PRIO_W   = 32;
  localparam int ITEM_W   = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_REM_RD,
    S_REM_LD,
    S_DN_RD,
    S_DN_CMP,
    S_DN_WR,
    S_TOP_RD,
    S_TOP_LD,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [PRIO_W-1:0] priority_req;
    logic [ITEM_W-1:0]        item_tag;
  } mhpq_req_t;

  typedef struct packed {
    status_e                  status;
    logic [ITEM_W-1:0]        removed_item;
    logic signed [PRIO_W-1:0] removed_priority;
    logic                     top_valid;
    logic [ITEM_W-1:0]        top_item;
    logic signed [PRIO_W-1:0] top_priority;
    logic [CNT_W-1:0]         entry_count;
  } mhpq_rsp_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [ITEM_W-1:0]        item;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

endpackage

FILE: hdl/mhpq_ram.sv
module mhpq_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/mhpq_core.sv
module mhpq_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mhpq_pkg::mhpq_req_t req_i,
  output mhpq_pkg::mem_req_t  mem_o,
  input  mhpq_pkg::entry_t    rd_a_i,
  input  mhpq_pkg::entry_t    rd_b_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output mhpq_pkg::mhpq_rsp_t res_o
);

  import mhpq_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  entry_t            ent_q, ent_d;
  entry_t            rem_q, rem_d;
  status_e           status_q, status_d;
  mhpq_rsp_t         res_q, res_d;

  logic [ADDR_W-1:0]  par;
  logic [ADDR_W-1:0]  last_addr;
  logic [CHILD_W-1:0] lchild;
  logic [CHILD_W-1:0] rchild;
  logic [CHILD_W-1:0] size_ext;
  logic               l_in;
  logic               r_in;
  logic               pick_r;
  entry_t             small_ent;
  logic [ADDR_W-1:0]  small_idx;
  logic               full;
  logic               accept;

  // implicit tree: parent (p-1)/2, children 2p+1 and 2p+2
  assign par       = (pos_q - ADDR_W'(1)) >> 1;
  assign last_addr = ADDR_W'(size_q - CNT_W'(1));
  assign lchild    = {1'b0, pos_q, 1'b1};
  assign rchild    = lchild + CHILD_W'(1);
  assign size_ext  = CHILD_W'(size_q);
  assign l_in      = lchild < size_ext;
  assign r_in      = rchild < size_ext;
  // equal children: right one wins
  assign pick_r    = r_in && !(rd_a_i.prio < rd_b_i.prio);
  assign small_ent = pick_r ? rd_b_i : rd_a_i;
  assign small_idx = pick_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
  assign full      = size_q == CNT_W'(CAPACITY);
  assign accept    = in_valid_i && (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_i.cmd == CMD_INSERT) begin
            if (full) begin
              state_d = S_TOP_RD;
            end else if (size_q == '0) begin
              state_d = S_INS_WR;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            state_d = (size_q == '0) ? S_TOP_RD : S_REM_RD;
          end
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (ent_q.prio < rd_a_i.prio) begin
          state_d = (par == '0) ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR:  state_d = S_TOP_RD;
      S_REM_RD:  state_d = S_REM_LD;
      S_REM_LD:  state_d = (size_q == CNT_W'(1)) ? S_TOP_RD : S_DN_RD;
      S_DN_RD:   state_d = l_in ? S_DN_CMP : S_DN_WR;
      S_DN_CMP:  state_d = (small_ent.prio < ent_q.prio) ? S_DN_RD : S_DN_WR;
      S_DN_WR:   state_d = S_TOP_RD;
      S_TOP_RD:  state_d = S_TOP_LD;
      S_TOP_LD:  state_d = S_DONE;
      S_DONE:    state_d = res_ready_i ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    size_d        = size_q;
    pos_d         = pos_q;
    ent_d         = ent_q;
    rem_d         = rem_q;
    status_d      = status_q;
    res_d         = res_q;
    mem_o.we      = 1'b0;
    mem_o.waddr   = pos_q;
    mem_o.wdata   = ent_q;
    mem_o.raddr_a = '0;
    mem_o.raddr_b = last_addr;
    res_valid_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d   = STATUS_OK;
          rem_d      = '0;
          ent_d.prio = req_i.priority_req;
          ent_d.item = req_i.item_tag;
          if (req_i.cmd == CMD_INSERT) begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              pos_d  = size_q[ADDR_W-1:0];
              size_d = size_q + CNT_W'(1);
            end
          end else if (size_q == '0) begin
            status_d = STATUS_EMPTY;
          end
        end
      end
      S_INS_RD: begin
        mem_o.raddr_a = par;
      end
      S_INS_CMP: begin
        // parent moves down into the hole
        if (ent_q.prio < rd_a_i.prio) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = rd_a_i;
          pos_d       = par;
        end
      end
      S_INS_WR, S_DN_WR: begin
        mem_o.we = 1'b1;
      end
      S_REM_RD: begin
        mem_o.raddr_a = '0;
        mem_o.raddr_b = last_addr;
      end
      S_REM_LD: begin
        rem_d  = rd_a_i;
        ent_d  = rd_b_i;
        size_d = size_q - CNT_W'(1);
        pos_d  = '0;
      end
      S_DN_RD: begin
        mem_o.raddr_a = lchild[ADDR_W-1:0];
        mem_o.raddr_b = rchild[ADDR_W-1:0];
      end
      S_DN_CMP: begin
        // smaller child moves up into the hole
        if (small_ent.prio < ent_q.prio) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = small_ent;
          pos_d       = small_idx;
        end
      end
      S_TOP_RD: begin
        mem_o.raddr_a = '0;
      end
      S_TOP_LD: begin
        res_d.status           = status_q;
        res_d.removed_item     = rem_q.item;
        res_d.removed_priority = rem_q.prio;
        res_d.top_valid        = size_q != '0;
        res_d.top_item         = (size_q != '0) ? rd_a_i.item : '0;
        res_d.top_priority     = (size_q != '0) ? rd_a_i.prio : '0;
        res_d.entry_count      = size_q;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    ent_q    <= ent_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign in_stall_o = state_q != S_IDLE;
  assign res_o      = res_q;

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_size_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_REM_LD) |=> $stable(size_q))
    else $error("entry count changed during a sift");

  a_rem_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM_LD) |=> (size_q == $past(size_q) - CNT_W'(1)))
    else $error("remove did not drop the count by one");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (state_q == S_INS_CMP || state_q == S_INS_WR ||
                  state_q == S_DN_CMP || state_q == S_DN_WR))
    else $error("memory write outside a sift step");

  a_child_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_CMP) |-> l_in)
    else $error("sift-down compare without a left child");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after handing over a result");

endmodule

FILE: hdl/min_heap_priority_queue.sv
// channel | direction | handshake             | word
// --------+-----------+-----------------------+--------------------------------
// in      | input     | in_valid_i/in_stall_o | mhpq_req_t (cmd, priority, tag)
// out     | output    | out_valid_o/out_stall_i | mhpq_rsp_t (status, removed, top)
//
// one word at a time: an insert compares a parent per level, then writes; a remove
// reads root and last entry, then compares both children per level and writes; an
// error or a remove that empties the heap skips the sift. each word then reads the root
// for the top field; the sift loop through the registered-read heap memory bounds the time.
// the result register lets the next word be taken while a result waits on stall; a second
// result waits in the sequencer. reset clears count, sequencer, out valid.
module min_heap_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mhpq_pkg::mhpq_req_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhpq_pkg::mhpq_rsp_t out_word_o
);

  import mhpq_pkg::*;

  mem_req_t  mem_req;
  entry_t    rd_a;
  entry_t    rd_b;
  logic      res_valid;
  logic      res_ready;
  mhpq_rsp_t res;
  logic      out_valid_q, out_valid_d;
  mhpq_rsp_t out_word_q, out_word_d;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t)),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (mem_req.we),
    .waddr_i  (mem_req.waddr),
    .wdata_i  (mem_req.wdata),
    .raddr_a_i(mem_req.raddr_a),
    .raddr_b_i(mem_req.raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  mhpq_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_word_i),
    .mem_o      (mem_req),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // result register takes a new word when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_word_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: bench/tb_min_heap_priority_queue.sv
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 40;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  mhpq_req_t in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  mhpq_rsp_t out_word_o;

  min_heap_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // shadow heap
  logic signed [PRIO_W-1:0] heap_prio [CAPACITY];
  logic [ITEM_W-1:0]        heap_item [CAPACITY];
  int unsigned              heap_n = 0;
  mhpq_rsp_t                heap_rsp_q [$];

  int errors = 0;
  int cycles = 0;
  int words_checked = 0;
  int n_insert = 0, n_remove = 0, n_empty = 0, n_full = 0, peak_n = 0;
  int in_run = 0, out_run = 0, stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $display("timeout after %0d cycles, %0d words outstanding", cycles, heap_rsp_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic signed [PRIO_W-1:0] tp;
    logic [ITEM_W-1:0]        ti;
    tp = heap_prio[a];
    ti = heap_item[a];
    heap_prio[a] = heap_prio[b];
    heap_item[a] = heap_item[b];
    heap_prio[b] = tp;
    heap_item[b] = ti;
  endfunction

  function automatic mhpq_rsp_t heap_op(input mhpq_req_t w);
    mhpq_rsp_t   r;
    int unsigned pos, par, lc, rc, pick;
    r = '0;
    r.status = STATUS_OK;
    if (w.cmd == CMD_INSERT) begin
      if (heap_n >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        pos = heap_n;
        heap_prio[pos] = w.priority_req;
        heap_item[pos] = w.item_tag;
        heap_n++;
        // move up only while strictly smaller than the parent
        while (pos != 0) begin
          par = (pos - 1) / 2;
          if (!(heap_prio[pos] < heap_prio[par])) break;
          swap_slots(pos, par);
          pos = par;
        end
      end
    end else if (heap_n == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.removed_item     = heap_item[0];
      r.removed_priority = heap_prio[0];
      heap_n--;
      heap_prio[0] = heap_prio[heap_n];
      heap_item[0] = heap_item[heap_n];
      pos = 0;
      forever begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= heap_n) break;
        // tie between children goes to the right one
        pick = lc;
        if (rc < heap_n && !(heap_prio[lc] < heap_prio[rc])) pick = rc;
        if (!(heap_prio[pick] < heap_prio[pos])) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    end
    if (heap_n > 0) begin
      r.top_valid    = 1'b1;
      r.top_item     = heap_item[0];
      r.top_priority = heap_prio[0];
    end
    r.entry_count = heap_n[CNT_W-1:0];
    return r;
  endfunction

  function automatic mhpq_req_t make_word(input cmd_e c, input logic signed [PRIO_W-1:0] p,
                                          input logic [ITEM_W-1:0] t);
    mhpq_req_t w;
    w.cmd          = c;
    w.priority_req = p;
    w.item_tag     = t;
    return w;
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2: p = $urandom;
      // narrow band so equal priorities are common
      3, 4, 5: p = $signed($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 3))
          0:       p = 32'sh7fffffff;
          1:       p = 32'sh80000000;
          2:       p = 0;
          default: p = -1;
        endcase
      end
      default: p = $signed($urandom_range(0, 2000)) - 1000;
    endcase
    return p;
  endfunction

  function automatic logic [ITEM_W-1:0] pick_item();
    logic [ITEM_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = '1;
      default: t = $urandom;
    endcase
    return t;
  endfunction

  task automatic send_word(input mhpq_req_t w);
    int        gap;
    mhpq_rsp_t r;
    if (in_run > 0) begin
      in_run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 49) == 0) in_run = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = heap_op(w);
    heap_rsp_q.push_back(r);
    if (w.cmd == CMD_INSERT) n_insert++;
    else n_remove++;
    if (r.status == STATUS_EMPTY) n_empty++;
    if (r.status == STATUS_FULL) n_full++;
    if (heap_n > peak_n) peak_n = heap_n;
  endtask

  // insert with the given chance in percent, else remove with junk payload
  task automatic random_op(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct)
      send_word(make_word(CMD_INSERT, pick_priority(), pick_item()));
    else
      send_word(make_word(CMD_REMOVE, pick_priority(), pick_item()));
  endtask

  task automatic test_directed_cases();
    send_word(make_word(CMD_REMOVE, 32'sh7fffffff, '1));
    send_word(make_word(CMD_INSERT, 32'sh7fffffff, '0));
    send_word(make_word(CMD_INSERT, 5, 32'h0000_000a));
    send_word(make_word(CMD_INSERT, 5, 32'h0000_000b));
    send_word(make_word(CMD_INSERT, 5, 32'h0000_000c));
    send_word(make_word(CMD_INSERT, 0, 32'h5555_5555));
    send_word(make_word(CMD_INSERT, -1, 32'haaaa_aaaa));
    send_word(make_word(CMD_INSERT, 32'sh80000000, '1));
    send_word(make_word(CMD_INSERT, -1, 32'h1234_5678));
    repeat (8) send_word(make_word(CMD_REMOVE, 32'sh80000000, '0));
    send_word(make_word(CMD_REMOVE, '0, '0));
  endtask

  task automatic test_random_mix();
    // hovers near empty so removes on an empty heap show up
    repeat (200) random_op(45);
  endtask

  task automatic test_fill_to_capacity();
    while (heap_n < CAPACITY) random_op(95);
    // bounce on the full boundary
    repeat (24) random_op(65);
  endtask

  task automatic test_drain_from_full();
    repeat (300) random_op(15);
  endtask

  task automatic check_word(input mhpq_rsp_t e, input mhpq_rsp_t g);
    if (g.status !== e.status)
      report_error($sformatf("word %0d status exp %0d got %0d", words_checked, e.status,
                             g.status));
    if (g.removed_item !== e.removed_item)
      report_error($sformatf("word %0d removed_item exp %h got %h", words_checked,
                             e.removed_item, g.removed_item));
    if (g.removed_priority !== e.removed_priority)
      report_error($sformatf("word %0d removed_priority exp %0d got %0d", words_checked,
                             e.removed_priority, g.removed_priority));
    if (g.top_valid !== e.top_valid)
      report_error($sformatf("word %0d top_valid exp %b got %b", words_checked, e.top_valid,
                             g.top_valid));
    if (g.top_item !== e.top_item)
      report_error($sformatf("word %0d top_item exp %h got %h", words_checked, e.top_item,
                             g.top_item));
    if (g.top_priority !== e.top_priority)
      report_error($sformatf("word %0d top_priority exp %0d got %0d", words_checked,
                             e.top_priority, g.top_priority));
    if (g.entry_count !== e.entry_count)
      report_error($sformatf("word %0d entry_count exp %0d got %0d", words_checked,
                             e.entry_count, g.entry_count));
  endtask

  always @(posedge clk_i) begin : result_side
    mhpq_rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (heap_rsp_q.size() == 0) begin
          report_error($sformatf("result word with nothing outstanding, count %0d",
                                 out_word_o.entry_count));
        end else begin
          e = heap_rsp_q.pop_front();
          check_word(e, out_word_o);
        end
        words_checked++;
        if (out_run > 0) begin
          out_run--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 9);
          if ($urandom_range(0, 49) == 0) out_run = $urandom_range(10, 60);
        end
        out_stall_i <= (stall_left > 0);
      end else if (out_valid_o && out_stall_i) begin
        // count stall only against a waiting word
        if (stall_left > 0) stall_left--;
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_mix();
    test_fill_to_capacity();
    test_drain_from_full();
    in_valid_i <= 1'b0;
    while (heap_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d inserts (%0d on a full heap) and %0d removes (%0d on an empty heap)",
             n_insert, n_full, n_remove, n_empty);
    $display("heap peaked at %0d entries; %0d result words checked, %0d mismatches",
             peak_n, words_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
